/* rtl/mslbt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mslbt_pkg: shared types and constants for the multi-slot LED blink timer
// Slot count, LED count, field widths, command codes and slot interface types.
// ----------------------------------------------------------------------------
package mslbt_pkg;

    localparam int SLOTS     = 4;
    localparam int LED_COUNT = 4;

    localparam int LED_ID_W  = 2;
    localparam int REPEAT_W  = 16;
    localparam int TICKS_W   = 24;
    localparam int OUT_BITS  = 4;   // LEDs and slots shown in a result

    // input tdata: led_id, repeat_count, on_ticks, off_ticks, padded to bytes
    localparam int IN_FIELDS_W = LED_ID_W + REPEAT_W + 2 * TICKS_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    // output tdata: led_levels, start_taken, active_slots, padded to bytes
    localparam int OUT_FIELDS_W = OUT_BITS + 1 + OUT_BITS;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic tick;     // handle a millisecond tick
        logic load;     // claim this slot for a start request
    } slot_ctl_t;

    typedef struct packed {
        logic [LED_ID_W-1:0] led;
        logic [REPEAT_W-1:0] repeats;
        logic [TICKS_W-1:0]  on_ticks;
        logic [TICKS_W-1:0]  off_ticks;
    } slot_load_t;

    typedef struct packed {
        logic [LED_ID_W-1:0] led;       // LED this slot drives
        logic                led_on;    // switch LED on this tick
        logic                led_off;   // switch LED off this tick
        logic                active;    // count nonzero now
        logic                active_next;
    } slot_stat_t;

endpackage

/* rtl/mslbt_slot.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mslbt_slot: one blink slot
// Holds the repeat count, reload values, running timers and LED number of a
// slot; loads on a start request and steps its timers on a tick.
// ----------------------------------------------------------------------------
module mslbt_slot
    import mslbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  slot_ctl_t  ctl,
    input  slot_load_t load_data,
    output slot_stat_t stat
);

    logic [REPEAT_W-1:0] repeats_reg,    repeats_next;
    logic [TICKS_W-1:0]  on_reload_reg,  on_reload_next;
    logic [TICKS_W-1:0]  off_reload_reg, off_reload_next;
    logic [TICKS_W-1:0]  on_left_reg,    on_left_next;
    logic [TICKS_W-1:0]  off_left_reg,   off_left_next;
    logic [LED_ID_W-1:0] led_reg,        led_next;
    logic                ev_on, ev_off;

    always_comb
    begin
        repeats_next    = repeats_reg;
        on_reload_next  = on_reload_reg;
        off_reload_next = off_reload_reg;
        on_left_next    = on_left_reg;
        off_left_next   = off_left_reg;
        led_next        = led_reg;
        ev_on           = 1'b0;
        ev_off          = 1'b0;
        if (ctl.load)
        begin
            repeats_next    = load_data.repeats;
            on_reload_next  = load_data.on_ticks;
            off_reload_next = load_data.off_ticks;
            on_left_next    = load_data.on_ticks;
            off_left_next   = load_data.off_ticks;
            led_next        = load_data.led;
        end
        else if (ctl.tick && repeats_reg != '0)
        begin
            if (on_left_reg != '0)
            begin
                on_left_next = on_left_reg - TICKS_W'(1);
                ev_off       = (on_left_reg == TICKS_W'(1));
            end
            else if (off_left_reg != '0)
            begin
                off_left_next = off_left_reg - TICKS_W'(1);
                if (off_left_reg == TICKS_W'(1))
                begin
                    repeats_next = repeats_reg - REPEAT_W'(1);
                    // another repeat to go: reload both timers, LED back on
                    if (repeats_reg != REPEAT_W'(1))
                    begin
                        on_left_next  = on_reload_reg;
                        off_left_next = off_reload_reg;
                        ev_on         = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeats_reg    <= '0;
            on_reload_reg  <= '0;
            off_reload_reg <= '0;
            on_left_reg    <= '0;
            off_left_reg   <= '0;
            led_reg        <= '0;
        end
        else if (advance)
        begin
            repeats_reg    <= repeats_next;
            on_reload_reg  <= on_reload_next;
            off_reload_reg <= off_reload_next;
            on_left_reg    <= on_left_next;
            off_left_reg   <= off_left_next;
            led_reg        <= led_next;
        end
    end

    assign stat.led         = led_reg;
    assign stat.led_on      = ev_on;
    assign stat.led_off     = ev_off;
    assign stat.active      = (repeats_reg != '0);
    assign stat.active_next = (repeats_next != '0);

endmodule

/* rtl/multi_slot_led_blink_timer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_led_blink_timer_top: multi-slot LED blink timer
// Ticks and start requests drive a bank of blink slots; one result per item.
//
//  channel | dir | signals                          | carries
//  --------+-----+----------------------------------+---------------------------
//  s_*     | in  | tvalid tready tdata[71:0] tuser  | tick or start request
//  m_*     | out | tvalid tready tdata[15:0]        | LED levels, taken, active
//
// An item is registered on transfer, handled by the slot logic and LED
// resolve once the result register is free or being taken, and lands in the
// result register; one item per cycle is sustained while results are taken.
// A held result stalls the input register; s_tready stays high while the
// result register is free or being taken. Reset clears all slots and LEDs.
// ----------------------------------------------------------------------------
module multi_slot_led_blink_timer_top
    import mslbt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [1:0] led_id, [17:2] repeat_count, [41:18] on_ticks, [65:42] off_ticks
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // [0] cmd
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [3:0] led_levels, [4] start_taken, [8:5] active_slots
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    // input register
    logic             in_valid_reg;
    logic             in_cmd_reg;
    slot_load_t       in_data_reg;

    // result register
    logic                out_valid_reg;
    logic [OUT_BITS-1:0] out_levels_reg, out_levels_next;
    logic                out_taken_reg,  out_taken_next;
    logic [OUT_BITS-1:0] out_active_reg, out_active_next;

    logic [LED_COUNT-1:0] led_drive_reg, led_drive_next;

    logic       advance;
    logic       found;
    slot_ctl_t  ctl      [SLOTS];
    slot_stat_t stat     [SLOTS];
    logic [SLOTS-1:0] active_now;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg            <= s_tuser;
            in_data_reg.led       <= s_tdata[LED_ID_W-1:0];
            in_data_reg.repeats   <= s_tdata[LED_ID_W +: REPEAT_W];
            in_data_reg.on_ticks  <= s_tdata[LED_ID_W + REPEAT_W +: TICKS_W];
            in_data_reg.off_ticks <= s_tdata[LED_ID_W + REPEAT_W + TICKS_W +: TICKS_W];
        end
    end

    // first free slot takes a start request
    always_comb
    begin
        found = 1'b0;
        for (int s = 0; s < SLOTS; s++)
        begin
            ctl[s].tick = (in_cmd_reg == CMD_TICK);
            ctl[s].load = 1'b0;
            if (in_cmd_reg == CMD_START && !found && !stat[s].active)
            begin
                ctl[s].load = 1'b1;
                found       = 1'b1;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_slot
            mslbt_slot u_slot (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .ctl       (ctl[g]),
                .load_data (in_data_reg),
                .stat      (stat[g])
            );
            assign active_now[g] = stat[g].active;
        end
    endgenerate

    // LED resolve: a taken start switches its LED on; on a tick, slots in index order, later slot wins
    always_comb
    begin
        led_drive_next = led_drive_reg;
        if (in_cmd_reg == CMD_START)
        begin
            if (found && int'(in_data_reg.led) < LED_COUNT)
                led_drive_next[in_data_reg.led] = 1'b1;
        end
        else
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                if (int'(stat[s].led) < LED_COUNT)
                begin
                    if (stat[s].led_on)
                        led_drive_next[stat[s].led] = 1'b1;
                    if (stat[s].led_off)
                        led_drive_next[stat[s].led] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        out_levels_next = '0;
        out_active_next = '0;
        for (int i = 0; i < OUT_BITS; i++)
        begin
            if (i < LED_COUNT)
                out_levels_next[i] = led_drive_next[i];
            if (i < SLOTS)
                out_active_next[i] = stat[i].active_next;
        end
        out_taken_next = found;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_drive_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                led_drive_reg <= led_drive_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_levels_reg <= out_levels_next;
            out_taken_reg  <= out_taken_next;
            out_active_reg <= out_active_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                       out_active_reg, out_taken_reg, out_levels_reg};

    // a tick never reports a taken start
    a_tick_not_taken: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_cmd_reg == CMD_TICK |=> !out_taken_reg)
        else $error("tick reported start_taken");

    // a start with every slot busy changes no LED
    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_cmd_reg == CMD_START && (&active_now)
        |=> !out_taken_reg && $stable(led_drive_reg))
        else $error("start taken with no free slot");

    // reported active slots match the slot bank while a result is held
    a_active_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_active_reg == OUT_BITS'(active_now))
        else $error("active_slots out of step with slots");

    // input only stalls behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a held result");

endmodule
